### hw/rtl/pngu_pkg.sv
// ----------------------------------------------------------------------------
// pngu_pkg: PNG scanline unfilter shared definitions
// Filter codes, register indexes, field widths, the staged word type and
// the Paeth predictor.
// ----------------------------------------------------------------------------
package pngu_pkg;

   localparam int LINE_MAX_BYTES_DEF  = 8192;
   localparam int MAX_PIXEL_BYTES_DEF = 8;

   localparam int LINE_BYTES_W  = 14;
   localparam int PIXEL_BYTES_W = 4;
   localparam int CSR_DATA_W    = 14;

   localparam logic CSR_LINE_BYTES  = 1'b0;
   localparam logic CSR_PIXEL_BYTES = 1'b1;

   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;
   localparam logic [2:0] FILT_BAD   = 3'd5;

   typedef struct packed {
      logic [7:0] data;
      logic [2:0] filter;
      logic       has_left;
      logic       first_row;
      logic       last;
   } pngu_item_type;

   function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic        [9:0] pa;
      logic        [9:0] pb;
      logic        [9:0] pc;
      logic [7:0]        res;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = da + db;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         res = a;
      end else if (pb <= pc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

### hw/rtl/pngu_predict.sv
// ----------------------------------------------------------------------------
// pngu_predict: unfilter datapath
// Line store with registered read, left and upper-left history, and the
// None / Sub / Up / Average / Paeth reconstruction of one byte.
// ----------------------------------------------------------------------------
module pngu_predict #(
   parameter int LINE_MAX_BYTES  = pngu_pkg::LINE_MAX_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF,
   localparam int AW = $clog2(LINE_MAX_BYTES),
   localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   input  logic                    upd,
   input  logic [AW-1:0]           wr_addr,
   input  logic [HW-1:0]           hist_sel,
   input  pngu_pkg::pngu_item_type item,
   output logic [7:0]              pixel
);
   import pngu_pkg::*;

   logic [7:0] line_mem [LINE_MAX_BYTES];
   logic [7:0] up_rd_ff;
   logic [7:0] left_hist_ff [MAX_PIXEL_BYTES];
   logic [7:0] upleft_hist_ff [MAX_PIXEL_BYTES];
   logic [7:0] a_val;
   logic [7:0] b_val;
   logic [7:0] c_val;
   logic [8:0] avg_sum;
   logic [7:0] pred;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_rd_ff <= line_mem[rd_addr];
      end
      if (upd) begin
         line_mem[wr_addr] <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
            left_hist_ff[i]   <= 8'd0;
            upleft_hist_ff[i] <= 8'd0;
         end
      end else if (upd) begin
         for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
            left_hist_ff[i]   <= left_hist_ff[i-1];
            upleft_hist_ff[i] <= upleft_hist_ff[i-1];
         end
         left_hist_ff[0]   <= pixel;
         upleft_hist_ff[0] <= b_val;
      end
   end

   always_comb begin
      b_val   = item.first_row ? 8'd0 : up_rd_ff;
      a_val   = item.has_left ? left_hist_ff[hist_sel] : 8'd0;
      c_val   = (item.has_left && !item.first_row) ? upleft_hist_ff[hist_sel] : 8'd0;
      avg_sum = {1'b0, a_val} + {1'b0, b_val};
      case (item.filter)
         FILT_NONE:  pred = 8'd0;
         FILT_SUB:   pred = a_val;
         FILT_UP:    pred = b_val;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth(a_val, b_val, c_val);
         default:    pred = 8'd0;
      endcase
      pixel = item.data + pred;
   end

endmodule

### hw/rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter: PNG scanline reconstruction (filter method 0)
// Takes one byte word per cycle while rsp does not stall; filter bytes yield
// no result, each data byte yields one reconstructed byte at rsp.
// ----------------------------------------------------------------------------
// Sustains one byte per cycle with no gaps, also across line boundaries, while
// rsp does not stall; a data byte's result passes the predictor stage and the
// output register. The line store sets the pace: one read (when the byte is
// taken) and one write (when it leaves the predictor stage) per cycle. Only a
// result waiting at rsp with the predictor stage full drops req_tready. The
// user must write line_bytes and pixel_bytes only while idle; not enforced.
module png_scanline_unfilter #(
   parameter int LINE_MAX_BYTES  = pngu_pkg::LINE_MAX_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = pngu_pkg::MAX_PIXEL_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // data_byte
   input  logic                            req_tuser,  // image_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // pixel_byte
   output logic                            rsp_tlast,  // line_end
   output logic                            rsp_tuser,  // bad_filter
   input  logic                            csr_we,
   input  logic                            csr_addr,
   input  logic [pngu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pngu_pkg::*;

   localparam int AW    = $clog2(LINE_MAX_BYTES);
   localparam int HW    = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int LEN_W = $clog2(LINE_MAX_BYTES + 1);
   localparam int CW    = (LEN_W > LINE_BYTES_W) ? LEN_W : LINE_BYTES_W;

   logic [LINE_BYTES_W-1:0]  line_bytes_ff;
   logic [PIXEL_BYTES_W-1:0] pixel_bytes_ff;
   logic                     in_line_ff, in_line_in;
   logic                     first_row_ff, first_row_in;
   logic [2:0]               filter_ff, filter_in;
   logic [AW-1:0]            x_ff, x_in;
   logic                     s1_valid_ff, s1_valid_in;
   pngu_item_type            s1_item_ff, s1_item_in;
   logic [AW-1:0]            s1_addr_ff;
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_data_ff;
   logic                     rsp_last_ff;
   logic                     rsp_bad_ff;

   logic                     s1_go;
   logic                     accept;
   logic                     take_filter;
   logic                     take_data;
   logic [CW-1:0]            len_raw;
   logic [CW-1:0]            len_eff;
   logic [PIXEL_BYTES_W-1:0] pb_eff;
   logic [HW-1:0]            hist_sel;
   logic                     is_last;
   logic [7:0]               pixel;

   assign s1_go       = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || s1_go;
   assign accept      = req_tvalid && req_tready;
   assign take_filter = accept && (req_tuser || !in_line_ff);
   assign take_data   = accept && !take_filter;

   always_comb begin
      len_raw = CW'(line_bytes_ff);
      if (len_raw == '0) begin
         len_eff = CW'(1);
      end else if (len_raw > CW'(LINE_MAX_BYTES)) begin
         len_eff = CW'(LINE_MAX_BYTES);
      end else begin
         len_eff = len_raw;
      end
      if (pixel_bytes_ff == '0) begin
         pb_eff = PIXEL_BYTES_W'(1);
      end else if (pixel_bytes_ff > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
         pb_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
      end else begin
         pb_eff = pixel_bytes_ff;
      end
      hist_sel = HW'(pb_eff - PIXEL_BYTES_W'(1));
      is_last  = (CW'(x_ff) + CW'(1)) >= len_eff;
   end

   always_comb begin
      in_line_in   = in_line_ff;
      first_row_in = first_row_ff;
      filter_in    = filter_ff;
      x_in         = x_ff;
      s1_item_in.data      = req_tdata;
      s1_item_in.filter    = filter_ff;
      s1_item_in.has_left  = x_ff >= AW'(pb_eff);
      s1_item_in.first_row = first_row_ff;
      s1_item_in.last      = is_last;
      if (take_filter) begin
         in_line_in = 1'b1;
         x_in       = '0;
         filter_in  = (req_tdata > 8'd4) ? FILT_BAD : req_tdata[2:0];
         if (req_tuser) begin
            first_row_in = 1'b1;
         end
      end else if (take_data) begin
         if (is_last) begin
            in_line_in   = 1'b0;
            first_row_in = 1'b0;
         end else begin
            x_in = x_ff + AW'(1);
         end
      end
      s1_valid_in = s1_valid_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      if (take_data) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff  <= LINE_BYTES_W'(1);
         pixel_bytes_ff <= PIXEL_BYTES_W'(1);
         in_line_ff     <= 1'b0;
         first_row_ff   <= 1'b1;
         filter_ff      <= FILT_NONE;
         x_ff           <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_LINE_BYTES:  line_bytes_ff  <= csr_wdata[LINE_BYTES_W-1:0];
               CSR_PIXEL_BYTES: pixel_bytes_ff <= csr_wdata[PIXEL_BYTES_W-1:0];
               default: ;
            endcase
         end
         in_line_ff   <= in_line_in;
         first_row_ff <= first_row_in;
         filter_ff    <= filter_in;
         x_ff         <= x_in;
         s1_valid_ff  <= s1_valid_in;
         if (s1_go) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_data) begin
         s1_item_ff <= s1_item_in;
         s1_addr_ff <= x_ff;
      end
      if (s1_go) begin
         rsp_data_ff <= pixel;
         rsp_last_ff <= s1_item_ff.last;
         rsp_bad_ff  <= (s1_item_ff.filter == FILT_BAD);
      end
   end

   pngu_predict #(
      .LINE_MAX_BYTES  (LINE_MAX_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_predict (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (take_data),
      .rd_addr  (x_ff),
      .upd      (s1_valid_ff && s1_go),
      .wr_addr  (s1_addr_ff),
      .hist_sel (hist_sel),
      .item     (s1_item_ff),
      .pixel    (pixel)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

### hw/rtl/pngu_checker.sv
// ----------------------------------------------------------------------------
// pngu_checker: port-level checks for png_scanline_unfilter
// Watches the stream ports and flags timing slips.
// ----------------------------------------------------------------------------
module pngu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word present after reset");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("rsp word without a req word two cycles before");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled while rsp side is free");

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);
